// File: rtl/hid_mouse_layout_extractor_macros.svh
// Assertion macros for the mouse layout extractor.
// Used by the top level only; no other dependencies.
`ifndef HID_MOUSE_LAYOUT_EXTRACTOR_MACROS_SVH
`define HID_MOUSE_LAYOUT_EXTRACTOR_MACROS_SVH
// Implication checked on every clock, off during reset.
`define HMLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Invariant checked on every clock, off during reset.
`define HMLE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

// File: rtl/hmle_pkg.sv
// Shared types and constants of the mouse layout extractor.
// No dependencies.
`timescale 1ns / 1ps
package hmle_pkg;
  localparam logic [7:0] TAG_INPUT    = 8'h80;
  localparam logic [7:0] TAG_COLL     = 8'hA0;
  localparam logic [7:0] TAG_END_COLL = 8'hC0;
  localparam logic [7:0] TAG_PAGE     = 8'h04;
  localparam logic [7:0] TAG_LMIN     = 8'h14;
  localparam logic [7:0] TAG_LMAX     = 8'h24;
  localparam logic [7:0] TAG_RSIZE    = 8'h74;
  localparam logic [7:0] TAG_RCOUNT   = 8'h94;
  localparam logic [7:0] TAG_RID      = 8'h84;
  localparam logic [7:0] TAG_USAGE    = 8'h08;
  localparam logic [7:0] RID_FLAGS    = 8'h85;
  localparam logic [31:0] DEF_SIZE    = 32'd8;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0, KIND_BUTTON = 3'd1, KIND_X = 3'd2, KIND_Y = 3'd3, KIND_WHEEL = 3'd4
  } kind_e;

  // One parser output per byte, handed from the parser to the executor; run marks a complete item.
  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] data;
    logic        last;
    logic        trunc;
    logic        run;
  } item_t;
endpackage

// File: rtl/hmle_front.sv
// Byte parser: assembles short items from descriptor bytes.
// Depends on hmle_pkg.
`timescale 1ns / 1ps
module hmle_front import hmle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] desc_byte_i,
  input  logic       last_byte_i,
  output logic       item_valid_o,
  output item_t      item_o
);
  logic [7:0]  hdr_q, hdr_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  len;
  logic [1:0]  pos;
  logic [31:0] dat;
  logic        run;

  // Decode one byte
  always_comb begin
    hdr_d = hdr_q;
    left_d = left_q;
    acc_d = acc_q;
    run = 1'b0;
    dat = '0;
    len = (hdr_q[1:0] == 2'd3) ? 3'd4 : {1'b0, hdr_q[1:0]};
    pos = 2'(len - left_q);
    if (left_q == 3'd0) begin
      hdr_d = desc_byte_i;
      acc_d = '0;
      left_d = (desc_byte_i[1:0] == 2'd3) ? 3'd4 : {1'b0, desc_byte_i[1:0]};
      run = (desc_byte_i[1:0] == 2'd0);
    end else begin
      acc_d = acc_q | (32'(desc_byte_i) << {pos, 3'b000});
      left_d = left_q - 3'd1;
      run = (left_d == 3'd0);
      dat = acc_d;
      if (len == 3'd2 && acc_d[15]) dat[31:16] = 16'hFFFF;
    end
    item_o.tag = {hdr_d[7:2], 2'b00};
    item_o.data = dat;
    item_o.run = run;
    item_o.last = last_byte_i;
    item_o.trunc = (left_d != 3'd0);
    if (last_byte_i) begin
      hdr_d = '0;
      left_d = '0;
      acc_d = '0;
    end
  end
  assign item_valid_o = push_i;

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
      left_q <= '0;
      acc_q <= '0;
    end else if (push_i) begin
      hdr_q <= hdr_d;
      left_q <= left_d;
      acc_q <= acc_d;
    end
  end
endmodule

// File: rtl/hmle_queue.sv
// Two-entry item queue between parser and executor.
// Depends on hmle_pkg.
`timescale 1ns / 1ps
module hmle_queue import hmle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output logic  nempty_o,
  output item_t rd_data_o
);
  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign nempty_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];

  // Store beat
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end
endmodule

// File: rtl/hmle_back.sv
// Item executor: tracks globals and places mouse fields; emits layout.
// Depends on hmle_pkg.
`timescale 1ns / 1ps
module hmle_back import hmle_pkg::*; #(
  parameter int USAGE_SLOTS = 3,
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  item_t       item_i,
  output logic        in_ready_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] buttons_width_o,
  output logic [15:0] buttons_offset_o,
  output logic [7:0]  wheel_width_o,
  output logic [15:0] wheel_offset_o,
  output logic [7:0]  x_width_o,
  output logic [15:0] x_offset_o,
  output logic [7:0]  y_width_o,
  output logic [15:0] y_offset_o,
  output logic signed [31:0] xy_min_o,
  output logic signed [31:0] xy_max_o,
  output logic [15:0] mouse_bits_total_o,
  output logic        truncated_o
);
  localparam logic [OFFSET_BITS:0] OffMax = {1'b0, {OFFSET_BITS{1'b1}}};

  logic [31:0] size_q, size_d, count_q, count_d, lmin_q, lmin_d, lmax_q, lmax_d;
  logic [31:0] page_q, page_d;
  logic [OFFSET_BITS-1:0] boff_q, boff_d, mtot_q, mtot_d;
  logic [7:0] depth_q, depth_d;
  logic mcount_q, mcount_d;
  kind_e kind_q [USAGE_SLOTS];
  kind_e kind_d [USAGE_SLOTS];
  logic [USAGE_SLOTS-1:0] en_q, en_d;
  logic [15:0] bw_q, bw_d, bo_q, bo_d, wo_q, wo_d, xo_q, xo_d, yo_q, yo_d;
  logic [7:0]  ww_q, ww_d, xw_q, xw_d, yw_q, yw_d;
  logic [31:0] mn_q, mn_d, mx_q, mx_d;
  // Output register
  logic        ov_q;
  logic [15:0] obw_q, obo_q, owo_q, oxo_q, oyo_q, otot_q;
  logic [7:0]  oww_q, oxw_q, oyw_q;
  logic [31:0] omn_q, omx_q;
  logic        otr_q;

  logic        take, place, flag_c, stop, found;
  logic [31:0] psize, pcount;
  logic [63:0] bits;
  logic [64:0] endp, offs;
  logic [OFFSET_BITS-1:0] start, offv;
  logic [15:0] bsat;
  logic [7:0]  wsat;

  assign in_ready_o = !ov_q || pop_i;
  assign take = in_valid_i && in_ready_o;

  // Execute one item
  always_comb begin
    size_d = size_q; count_d = count_q; lmin_d = lmin_q; lmax_d = lmax_q;
    page_d = page_q; boff_d = boff_q; mtot_d = mtot_q; depth_d = depth_q;
    mcount_d = mcount_q; kind_d = kind_q; en_d = en_q;
    bw_d = bw_q; bo_d = bo_q; ww_d = ww_q; wo_d = wo_q; xw_d = xw_q; xo_d = xo_q;
    yw_d = yw_q; yo_d = yo_q; mn_d = mn_q; mx_d = mx_q;
    place = 1'b0; flag_c = item_i.data[0];
    psize = (size_q == 0) ? DEF_SIZE : size_q;
    pcount = (count_q == 0) ? 32'd1 : count_q;
    if (item_i.tag == TAG_RID) begin
      psize = DEF_SIZE; pcount = 32'd1; flag_c = RID_FLAGS[0];
    end
    bits = 64'(psize) * 64'(pcount);
    start = boff_q;
    endp = 65'(start) + 65'(bits);
    bsat = (bits > 64'hFFFF) ? 16'hFFFF : bits[15:0];
    wsat = (psize > 32'd255) ? 8'hFF : psize[7:0];
    stop = 1'b0;
    offs = '0; offv = '0; found = 1'b0;
    if (item_i.run) begin
      unique case (item_i.tag)
        TAG_INPUT: begin
          if (count_q == 0 && size_q == 0) begin
            size_d = DEF_SIZE; count_d = 32'd1;
          end else begin
            place = 1'b1; size_d = '0; count_d = '0;
          end
        end
        TAG_RID: begin
          place = 1'b1; size_d = DEF_SIZE; count_d = 32'd1;
        end
        TAG_COLL: if (mcount_q) depth_d = depth_q + 8'd1;
        TAG_END_COLL: if (mcount_q) begin
          depth_d = depth_q - 8'd1;
          if (depth_d == 8'd0) mcount_d = 1'b0;
        end
        TAG_PAGE: begin
          page_d = item_i.data;
          if (item_i.data == 32'd9) begin
            kind_d[0] = KIND_BUTTON; en_d[0] = 1'b1;
          end
        end
        TAG_LMIN: lmin_d = item_i.data;
        TAG_LMAX: lmax_d = item_i.data;
        TAG_RSIZE: size_d = item_i.data;
        TAG_RCOUNT: count_d = item_i.data;
        TAG_USAGE: if (page_q == 32'd1) begin
          if (item_i.data == 32'h02) mcount_d = 1'b1;
          else if (item_i.data == 32'h30 || item_i.data == 32'h31 ||
                   item_i.data == 32'h38) begin
            // Queue into the first free slot
            for (int a = 0; a < USAGE_SLOTS; a++) begin
              if (!found && !en_q[a]) begin
                found = 1'b1;
                en_d[a] = 1'b1;
                kind_d[a] = (item_i.data == 32'h30) ? KIND_X :
                            (item_i.data == 32'h31) ? KIND_Y : KIND_WHEEL;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (place) begin
      boff_d = (endp > 65'(OffMax)) ? OffMax[OFFSET_BITS-1:0] : endp[OFFSET_BITS-1:0];
      if (mcount_q) mtot_d = boff_d;
      for (int a = 0; a < USAGE_SLOTS; a++) begin
        if (en_q[a] && !stop) begin
          if (flag_c) stop = 1'b1;
          else begin
            offs = (pcount > 32'd1) ? 65'(start) + 65'(psize) * 65'(a) : 65'(start);
            offv = (offs > 65'(OffMax)) ? OffMax[OFFSET_BITS-1:0] : offs[OFFSET_BITS-1:0];
            unique case (kind_q[a])
              KIND_X: begin
                xw_d = wsat; xo_d = 16'(offv); mn_d = lmin_q; mx_d = lmax_q; en_d[a] = 1'b0;
              end
              KIND_Y: begin
                yw_d = wsat; yo_d = 16'(offv); en_d[a] = 1'b0;
              end
              KIND_WHEEL: begin
                ww_d = wsat; wo_d = 16'(offv); en_d[a] = 1'b0;
              end
              KIND_BUTTON: begin
                bw_d = bsat; bo_d = 16'(start); en_d[a] = 1'b0;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  // Commit state; the last beat clears size, count, limits, offsets and layout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0; count_q <= '0; lmin_q <= '0; lmax_q <= '0; page_q <= '1;
      boff_q <= '0; mtot_q <= '0; depth_q <= '0; mcount_q <= 1'b0; en_q <= '0;
      for (int a = 0; a < USAGE_SLOTS; a++) kind_q[a] <= KIND_OTHER;
      bw_q <= '0; bo_q <= '0; ww_q <= '0; wo_q <= '0; xw_q <= '0; xo_q <= '0;
      yw_q <= '0; yo_q <= '0; mn_q <= '0; mx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (take && item_i.last) ov_q <= 1'b1;
      else if (pop_i && ov_q) ov_q <= 1'b0;
      if (take) begin
        page_q <= page_d; depth_q <= depth_d; mcount_q <= mcount_d;
        kind_q <= kind_d; en_q <= en_d;
        if (item_i.last) begin
          size_q <= '0; count_q <= '0; lmin_q <= '0; lmax_q <= '0;
          boff_q <= '0; mtot_q <= '0;
          bw_q <= '0; bo_q <= '0; ww_q <= '0; wo_q <= '0; xw_q <= '0; xo_q <= '0;
          yw_q <= '0; yo_q <= '0; mn_q <= '0; mx_q <= '0;
        end else begin
          size_q <= size_d; count_q <= count_d; lmin_q <= lmin_d; lmax_q <= lmax_d;
          boff_q <= boff_d; mtot_q <= mtot_d;
          bw_q <= bw_d; bo_q <= bo_d; ww_q <= ww_d; wo_q <= wo_d; xw_q <= xw_d;
          xo_q <= xo_d; yw_q <= yw_d; yo_q <= yo_d; mn_q <= mn_d; mx_q <= mx_d;
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      obw_q <= bw_d; obo_q <= bo_d; oww_q <= ww_d; owo_q <= wo_d;
      oxw_q <= xw_d; oxo_q <= xo_d; oyw_q <= yw_d; oyo_q <= yo_d;
      omn_q <= mn_d; omx_q <= mx_d; otot_q <= 16'(mtot_d); otr_q <= item_i.trunc;
    end
  end

  assign empty_o = !ov_q;
  assign buttons_width_o = obw_q;
  assign buttons_offset_o = obo_q;
  assign wheel_width_o = oww_q;
  assign wheel_offset_o = owo_q;
  assign x_width_o = oxw_q;
  assign x_offset_o = oxo_q;
  assign y_width_o = oyw_q;
  assign y_offset_o = oyo_q;
  assign xy_min_o = omn_q;
  assign xy_max_o = omx_q;
  assign mouse_bits_total_o = otot_q;
  assign truncated_o = otr_q;
endmodule

// File: rtl/hid_mouse_layout_extractor.sv
// Top level of the mouse layout extractor: parser, item queue, executor.
// Depends on hmle_pkg, hmle_front, hmle_queue, hmle_back and the macro header.
//
// Usage: push descriptor bytes with push while full is low, one per cycle.
// Mark the final byte with last_byte_i. One result per descriptor appears on
// the result ports when empty drops; take it with pop.
// Flow: the parser decodes a byte combinationally in the cycle it is pushed and
// writes the item into a two-entry queue; the executor takes it from the queue
// and registers the result, so empty drops once the result register is loaded
// with the item of the last byte.
// Throughput: one byte per cycle, set by the executor doing one item a cycle
// with one size-times-count multiply.
// When the receiver stalls the result register holds, the executor stops,
// the queue fills and full rises. Reset clears the control state: usage page all
// ones, slots empty, layout and counters zero; the result register is not reset.
`timescale 1ns / 1ps
`include "hid_mouse_layout_extractor_macros.svh"
module hid_mouse_layout_extractor import hmle_pkg::*; #(
  parameter int USAGE_SLOTS = 3,
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  desc_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] buttons_width_o,
  output logic [15:0] buttons_offset_o,
  output logic [7:0]  wheel_width_o,
  output logic [15:0] wheel_offset_o,
  output logic [7:0]  x_width_o,
  output logic [15:0] x_offset_o,
  output logic [7:0]  y_width_o,
  output logic [15:0] y_offset_o,
  output logic signed [31:0] xy_min_o,
  output logic signed [31:0] xy_max_o,
  output logic [15:0] mouse_bits_total_o,
  output logic        truncated_o
);
  item_t fr_item, q_item;
  logic  fr_valid, q_nempty, bk_ready, acc;

  assign acc = push && !full;

  hmle_front u_front (
    .clk_i, .rst_ni, .push_i(acc), .desc_byte_i, .last_byte_i,
    .item_valid_o(fr_valid), .item_o(fr_item)
  );

  hmle_queue u_queue (
    .clk_i, .rst_ni, .wr_i(fr_valid), .wr_data_i(fr_item), .full_o(full),
    .rd_i(q_nempty && bk_ready), .nempty_o(q_nempty), .rd_data_o(q_item)
  );

  hmle_back #(.USAGE_SLOTS(USAGE_SLOTS), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk_i, .rst_ni, .in_valid_i(q_nempty), .item_i(q_item), .in_ready_o(bk_ready),
    .empty_o(empty), .pop_i(pop),
    .buttons_width_o, .buttons_offset_o, .wheel_width_o, .wheel_offset_o,
    .x_width_o, .x_offset_o, .y_width_o, .y_offset_o, .xy_min_o, .xy_max_o,
    .mouse_bits_total_o, .truncated_o
  );

  `HMLE_ASSERT_IMPL(a_full_blocks, clk_i, rst_ni, full, !fr_valid)
  `HMLE_ASSERT_IMPL(a_result_holds, clk_i, rst_ni, !empty && !pop, ##1 !empty)
  `HMLE_ASSERT_IMPL(a_stall_drains, clk_i, rst_ni, !empty && !pop, !bk_ready)
endmodule

// File: tb/sv/hid_mouse_layout_extractor_tb.sv
// Self-checking testbench for hid_mouse_layout_extractor: streams descriptor bytes,
// predicts the mouse layout per descriptor and checks every result beat.
// Depends on hmle_pkg and the RTL of the block.
`timescale 1ns / 1ps
module hid_mouse_layout_extractor_tb;
  import hmle_pkg::*;

  localparam int          WATCHDOG_CYCLES = 2000;
  localparam int          RANDOM_BYTES    = 2000;
  localparam logic [31:0] OFF_SAT         = 32'd65535;
  localparam logic [31:0] PAGE_DESKTOP    = 32'd1;
  localparam logic [31:0] PAGE_BUTTON     = 32'd9;
  localparam logic [31:0] USE_MOUSE       = 32'h02;
  localparam logic [31:0] USE_X           = 32'h30;
  localparam logic [31:0] USE_Y           = 32'h31;
  localparam logic [31:0] USE_WHEEL       = 32'h38;

  typedef struct packed {
    logic [15:0] btn_w;
    logic [15:0] btn_o;
    logic [7:0]  whl_w;
    logic [15:0] whl_o;
    logic [7:0]  x_w;
    logic [15:0] x_o;
    logic [7:0]  y_w;
    logic [15:0] y_o;
    logic [31:0] lmin;
    logic [31:0] lmax;
    logic [15:0] total;
    logic        trunc;
  } layout_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         typed;
    layout_t    layout;
  } desc_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  desc_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] buttons_width_o, buttons_offset_o, wheel_offset_o, x_offset_o, y_offset_o;
  logic [15:0] mouse_bits_total_o;
  logic [7:0]  wheel_width_o, x_width_o, y_width_o;
  logic signed [31:0] xy_min_o, xy_max_o;
  logic        truncated_o;

  hid_mouse_layout_extractor u_dut (
    .clk_i, .rst_ni, .push, .full, .desc_byte_i, .last_byte_i, .empty, .pop,
    .buttons_width_o, .buttons_offset_o, .wheel_width_o, .wheel_offset_o,
    .x_width_o, .x_offset_o, .y_width_o, .y_offset_o, .xy_min_o, .xy_max_o,
    .mouse_bits_total_o, .truncated_o
  );

  // Parser and layout state mirrored from the block
  logic [7:0]  hdr_q;
  int unsigned left_q;
  logic [31:0] acc_q, page_q, size_q, count_q, lmin_q, lmax_q, offset_q, total_q;
  logic [7:0]  depth_q;
  bit          counting_q;
  kind_e       slot_kind_q [3];
  bit          slot_on_q [3];
  layout_t     layout_q;

  layout_t     layouts_due[$];
  desc_row_t   rows[$];
  logic [7:0]  burst_q[$];
  bit          idle_on = 1'b1;
  int          errors = 0;
  int          bytes_sent = 0;
  int          layouts_seen = 0;
  int          trunc_seen = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] clip(logic [63:0] v, logic [63:0] m);
    return (v > m) ? m[31:0] : v[31:0];
  endfunction

  function automatic int unsigned data_len(logic [7:0] h);
    return (h[1:0] == 2'd3) ? 4 : int'(h[1:0]);
  endfunction

  function automatic void clear_model();
    hdr_q = '0; left_q = 0; acc_q = '0; page_q = '1; size_q = '0; count_q = '0;
    lmin_q = '0; lmax_q = '0; offset_q = '0; total_q = '0; depth_q = '0;
    counting_q = 1'b0; layout_q = '0;
    for (int i = 0; i < 3; i++) begin
      slot_kind_q[i] = KIND_OTHER;
      slot_on_q[i] = 1'b0;
    end
  endfunction

  // Advance the bit offset and place pending slots on this field
  function automatic void place_slots(logic [7:0] flags);
    logic [63:0] start, bits;
    logic [31:0] off;
    start = {32'd0, offset_q};
    bits = {32'd0, size_q} * {32'd0, count_q};
    offset_q = clip(start + bits, OFF_SAT);
    if (counting_q) total_q = offset_q;
    for (int i = 0; i < 3; i++) begin
      if (!slot_on_q[i]) continue;
      if (flags[0]) return;
      off = clip((count_q > 1) ? start + {32'd0, size_q} * i : start, OFF_SAT);
      case (slot_kind_q[i])
        KIND_X: begin
          layout_q.x_w = 8'(clip(size_q, 255));
          layout_q.x_o = off[15:0];
          layout_q.lmin = lmin_q;
          layout_q.lmax = lmax_q;
          slot_on_q[i] = 1'b0;
        end
        KIND_Y: begin
          layout_q.y_w = 8'(clip(size_q, 255));
          layout_q.y_o = off[15:0];
          slot_on_q[i] = 1'b0;
        end
        KIND_WHEEL: begin
          layout_q.whl_w = 8'(clip(size_q, 255));
          layout_q.whl_o = off[15:0];
          slot_on_q[i] = 1'b0;
        end
        KIND_BUTTON: begin
          layout_q.btn_w = 16'(clip(bits, 64'hFFFF));
          layout_q.btn_o = 16'(clip(start, OFF_SAT));
          slot_on_q[i] = 1'b0;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void queue_slot(kind_e k);
    for (int i = 0; i < 3; i++) begin
      if (!slot_on_q[i]) begin
        slot_kind_q[i] = k;
        slot_on_q[i] = 1'b1;
        return;
      end
    end
  endfunction

  function automatic void exec_item(logic [7:0] h, logic [31:0] d);
    case (h & 8'hFC)
      TAG_INPUT: begin
        if (count_q == 0 && size_q == 0) begin
          count_q = 1;
          size_q = DEF_SIZE;
        end else begin
          if (size_q == 0) size_q = DEF_SIZE;
          if (count_q == 0) count_q = 1;
          place_slots(d[7:0]);
          count_q = 0;
          size_q = 0;
        end
      end
      TAG_COLL: if (counting_q) depth_q = depth_q + 8'd1;
      TAG_END_COLL: begin
        if (counting_q) begin
          depth_q = depth_q - 8'd1;
          if (depth_q == 0) counting_q = 1'b0;
        end
      end
      TAG_PAGE: begin
        page_q = d;
        if (d == PAGE_BUTTON) begin
          slot_kind_q[0] = KIND_BUTTON;
          slot_on_q[0] = 1'b1;
        end
      end
      TAG_LMIN:   lmin_q = d;
      TAG_LMAX:   lmax_q = d;
      TAG_RSIZE:  size_q = d;
      TAG_RCOUNT: count_q = d;
      TAG_RID: begin
        size_q = DEF_SIZE;
        count_q = 1;
        place_slots(RID_FLAGS);
      end
      TAG_USAGE: begin
        if (page_q == PAGE_DESKTOP) begin
          if (d == USE_MOUSE) counting_q = 1'b1;
          else if (d == USE_X) queue_slot(KIND_X);
          else if (d == USE_Y) queue_slot(KIND_Y);
          else if (d == USE_WHEEL) queue_slot(KIND_WHEEL);
        end
      end
      default: ;
    endcase
  endfunction

  // Consume one byte; returns 1 with the layout when the descriptor closes
  function automatic bit predict_layout(logic [7:0] b, logic last, output layout_t r);
    int unsigned n;
    logic [31:0] d;
    r = '0;
    if (left_q == 0) begin
      hdr_q = b;
      acc_q = '0;
      left_q = data_len(b);
      if (left_q == 0) exec_item(hdr_q, '0);
    end else begin
      n = data_len(hdr_q);
      acc_q |= {24'd0, b} << (8 * ((n - left_q) & 3));
      left_q--;
      if (left_q == 0) begin
        d = acc_q;
        if (n == 2 && d[15]) d[31:16] = '1;
        exec_item(hdr_q, d);
      end
    end
    if (!last) return 1'b0;
    r = layout_q;
    r.total = total_q[15:0];
    r.trunc = (left_q != 0);
    layout_q = '0;
    offset_q = '0; total_q = '0; size_q = '0; count_q = '0;
    lmin_q = '0; lmax_q = '0; hdr_q = '0; left_q = 0; acc_q = '0;
    return 1'b1;
  endfunction

  task automatic add_row(logic [7:0] b, logic last = 1'b0, bit typed = 1'b0,
                         layout_t e = '0);
    desc_row_t r;
    r.b = b; r.last = last; r.typed = typed; r.layout = e;
    rows.push_back(r);
  endtask

  // Drive one beat at the falling edge and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic last, bit typed, layout_t e);
    layout_t p;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    desc_byte_i = b;
    last_byte_i = last;
    do @(posedge clk_i); while (full);
    if (predict_layout(b, last, p)) layouts_due.push_back(typed ? e : p);
    bytes_sent++;
    @(negedge clk_i);
    push = 1'b0;
  endtask

  // Build one item with random data for the given tag into burst_q
  task automatic build_item(logic [7:0] tag);
    logic [1:0]  code;
    logic [31:0] d;
    code = 2'($urandom_range(0, 3));
    d = $urandom;
    case (tag)
      TAG_USAGE: begin
        case ($urandom_range(0, 4))
          0: d = USE_MOUSE;
          1: d = USE_X;
          2: d = USE_Y;
          3: d = USE_WHEEL;
          default: ;
        endcase
        if (d < 256 && code == 0) code = 1;
      end
      TAG_PAGE: begin
        case ($urandom_range(0, 3))
          0, 1: d = PAGE_DESKTOP;
          2: d = PAGE_BUTTON;
          default: ;
        endcase
        if (code == 0) code = 1;
      end
      TAG_RSIZE, TAG_RCOUNT: begin
        if ($urandom_range(0, 7) != 0) begin
          d = $urandom_range(0, 16);
          code = 1;
        end
      end
      default: ;
    endcase
    burst_q.push_back(tag | {6'd0, code});
    for (int i = 0; i < data_len({6'd0, code}); i++) burst_q.push_back(d[8*i +: 8]);
  endtask

  // Compare one field and count the mismatch
  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endtask

  // Take result beats and watch for a stalled handshake
  always @(posedge clk_i) begin
    layout_t e;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (pop && !empty) begin
        if (layouts_due.size() == 0) begin
          $error("result beat with no layout expected");
          errors++;
        end else begin
          e = layouts_due.pop_front();
          layouts_seen++;
          if (e.trunc) trunc_seen++;
          check_field("buttons_width", 32'(e.btn_w), 32'(buttons_width_o));
          check_field("buttons_offset", 32'(e.btn_o), 32'(buttons_offset_o));
          check_field("wheel_width", 32'(e.whl_w), 32'(wheel_width_o));
          check_field("wheel_offset", 32'(e.whl_o), 32'(wheel_offset_o));
          check_field("x_width", 32'(e.x_w), 32'(x_width_o));
          check_field("x_offset", 32'(e.x_o), 32'(x_offset_o));
          check_field("y_width", 32'(e.y_w), 32'(y_width_o));
          check_field("y_offset", 32'(e.y_o), 32'(y_offset_o));
          check_field("xy_min", e.lmin, xy_min_o);
          check_field("xy_max", e.lmax, xy_max_o);
          check_field("mouse_bits_total", 32'(e.total), 32'(mouse_bits_total_o));
          check_field("truncated", 32'(e.trunc), 32'(truncated_o));
        end
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && idle_on && $urandom_range(0, 6) == 0) stall = $urandom_range(1, 9);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    layout_t e;
    logic [7:0] tags[11];
    int cut;
    tags = '{TAG_INPUT, TAG_COLL, TAG_END_COLL, TAG_PAGE, TAG_LMIN, TAG_LMAX,
             TAG_RSIZE, TAG_RCOUNT, TAG_RID, TAG_USAGE, TAG_USAGE};
    clear_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty descriptor, truncated 4-byte item, then a small mouse layout
    add_row(8'h00, 1'b1, 1'b1, '0);
    e = '0;
    e.trunc = 1'b1;
    add_row(TAG_LMAX | 8'h03, 1'b1, 1'b1, e);
    add_row(TAG_INPUT);
    add_row(TAG_PAGE | 8'h01); add_row(8'h01);
    add_row(TAG_USAGE | 8'h01); add_row(8'h02);
    add_row(TAG_COLL);
    add_row(TAG_USAGE | 8'h01); add_row(8'h30);
    add_row(TAG_USAGE | 8'h01); add_row(8'h31);
    add_row(TAG_USAGE | 8'h01); add_row(8'h38);
    add_row(TAG_LMIN | 8'h02); add_row(8'h00); add_row(8'h80);
    add_row(TAG_RSIZE | 8'h01); add_row(8'hFF);
    add_row(TAG_RCOUNT | 8'h01); add_row(8'h03);
    add_row(TAG_INPUT | 8'h01); add_row(8'h02);
    add_row(TAG_END_COLL);
    add_row(8'hFF, 1'b1);
    foreach (rows[i]) send_byte(rows[i].b, rows[i].last, rows[i].typed, rows[i].layout);

    // Random descriptors: mostly well-formed items, some noise, some cut short
    while (bytes_sent < RANDOM_BYTES) begin
      burst_q.delete();
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(0, 4) == 0) burst_q.push_back(8'($urandom_range(0, 255)));
        else build_item(tags[$urandom_range(0, 10)]);
      end
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, burst_q.size());
        while (burst_q.size() > cut) void'(burst_q.pop_back());
      end
      if (bytes_sent > RANDOM_BYTES - 300) idle_on = 1'b0;
      foreach (burst_q[i]) send_byte(burst_q[i], i == burst_q.size() - 1, 1'b0, '0);
    end

    idle_on = 1'b0;
    while (layouts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("tb: %0d descriptor bytes sent, %0d layouts checked (%0d truncated)",
             bytes_sent, layouts_seen, trunc_seen);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/hmle_pkg.sv
rtl/hmle_front.sv
rtl/hmle_queue.sv
rtl/hmle_back.sv
rtl/hid_mouse_layout_extractor.sv
tb/sv/hid_mouse_layout_extractor_tb.sv
